// ===== sv/mcpwm_pkg.sv =====
`default_nettype none
package mcpwm_pkg;

  localparam int NumLeds    = 16;
  localparam int IdxW       = (NumLeds > 1) ? $clog2(NumLeds) : 1;
  localparam int LedIndexW  = 4;
  localparam int BrightW    = 8;
  localparam int CountW     = 8;

  localparam logic [CountW-1:0] CountTopReset = 8'd64;

  localparam logic KindTick  = 1'b0;
  localparam logic KindWrite = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic            wr_en;
    logic            shift_en;
    logic            last;
    logic [IdxW-1:0] idx;
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/mcpwm_ctrl.sv =====
`default_nettype none
module mcpwm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire logic            kind_i,
  output logic                 busy,
  output mcpwm_pkg::cmd_t      cmd_o
);

  typedef enum logic {
    StIdle,
    StShift
  } state_e;

  localparam logic [mcpwm_pkg::IdxW-1:0] LastIdx =
    mcpwm_pkg::IdxW'(mcpwm_pkg::NumLeds - 1);

  state_e                        state_q;
  logic [mcpwm_pkg::IdxW-1:0]    cnt_q;
  logic                          shifting;
  logic                          last;
  logic                          accept;

  assign shifting = (state_q == StShift);
  assign last     = shifting && (cnt_q == LastIdx);
  // the last bit cycle already takes the next request
  assign busy     = shifting && !last;
  assign accept   = start && !busy;

  always_comb begin
    cmd_o.wr_en    = accept && (kind_i == mcpwm_pkg::KindWrite);
    cmd_o.shift_en = shifting;
    cmd_o.last     = last;
    cmd_o.idx      = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      priority if (accept && (kind_i == mcpwm_pkg::KindTick)) begin
        state_q <= StShift;
        cnt_q   <= '0;
      end else if (shifting && !last) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (last) begin
        state_q <= StIdle;
      end else begin
        // idle with no tick: hold
        cnt_q <= cnt_q;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/mcpwm_dp.sv =====
`default_nettype none
module mcpwm_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mcpwm_pkg::cmd_t                     cmd_i,
  input  wire logic [mcpwm_pkg::LedIndexW-1:0]     led_index_i,
  input  wire logic [mcpwm_pkg::BrightW-1:0]       brightness_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [mcpwm_pkg::CountW-1:0]        cfg_data_i,
  output logic                                     strobe_o,
  output logic                                     led_bit_o,
  output logic                                     latch_o
);

  logic [mcpwm_pkg::BrightW-1:0] store_q [mcpwm_pkg::NumLeds];
  logic [mcpwm_pkg::CountW-1:0]  count_q;
  logic [mcpwm_pkg::CountW-1:0]  top_q;
  logic                          strobe_q;
  logic                          bit_q;
  logic                          latch_q;
  logic                          idx_ok;
  logic [mcpwm_pkg::IdxW-1:0]    wr_addr;
  logic [mcpwm_pkg::BrightW-1:0] rd_val;

  // writes to LEDs that do not exist are dropped
  assign idx_ok  = (32'(led_index_i) < 32'(mcpwm_pkg::NumLeds));
  assign wr_addr = mcpwm_pkg::IdxW'(led_index_i);
  assign rd_val  = store_q[cmd_i.idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mcpwm_pkg::NumLeds; i++) begin
        store_q[i] <= '0;
      end
      count_q  <= '0;
      top_q    <= mcpwm_pkg::CountTopReset;
      strobe_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en && idx_ok) begin
        store_q[wr_addr] <= brightness_i;
      end
      if (cfg_we_i) begin
        top_q <= cfg_data_i;
      end
      if (cmd_i.last) begin
        count_q <= (count_q < top_q) ? count_q + 1'b1 : '0;
      end
      strobe_q <= cmd_i.shift_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_en) begin
      bit_q   <= (rd_val > count_q);
      latch_q <= cmd_i.last;
    end
  end

  assign strobe_o  = strobe_q;
  assign led_bit_o = bit_q;
  assign latch_o   = latch_q;

endmodule
`default_nettype wire

// ===== sv/multichannel_pwm_serial_led_driver.sv =====
// tick request: first bit via controller state and strobe registers, one bit per cycle
// one bit per LED; the next tick is accepted in the last bit cycle of a frame
// write request: does not raise busy, no result, next request accepted the cycle after
// results cannot be stalled; each bit shows for exactly one cycle with strobe_o
// async active-low reset clears brightness store, pwm count and sets count top to 64
`default_nettype none
module multichannel_pwm_serial_led_driver (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              kind_i,
  input  wire logic [mcpwm_pkg::LedIndexW-1:0]   led_index_i,
  input  wire logic [mcpwm_pkg::BrightW-1:0]     brightness_i,
  output logic                                   strobe_o,
  output logic                                   led_bit_o,
  output logic                                   latch_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mcpwm_pkg::CountW-1:0]      cfg_data_i
);

  mcpwm_pkg::cmd_t cmd;

  assign cfg_ready_o = !busy;

  mcpwm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  mcpwm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .led_index_i  (led_index_i),
    .brightness_i (brightness_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .strobe_o     (strobe_o),
    .led_bit_o    (led_bit_o),
    .latch_o      (latch_o)
  );

endmodule
`default_nettype wire

// ===== sv/mcpwm_chk.sv =====
`default_nettype none
module mcpwm_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic kind_i,
  input wire logic strobe_o,
  input wire logic latch_o
);

  logic tick_acc;
  assign tick_acc = start && !busy && (kind_i == mcpwm_pkg::KindTick);

  // a tick keeps the block busy while its frame goes out
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> busy) else $error("tick request did not raise busy");

  // first bit of a frame follows the tick, through the controller state and strobe registers
  a_tick_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |-> ##2 (strobe_o && !latch_o)) else $error("frame did not start");

  // a frame is contiguous until the latch bit
  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !latch_o) |=> strobe_o) else $error("gap inside a frame");

  // latch marks are never back to back
  a_latch_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && latch_o) |=> !(strobe_o && latch_o)) else $error("double latch");

endmodule

bind multichannel_pwm_serial_led_driver mcpwm_chk u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .kind_i   (kind_i),
  .strobe_o (strobe_o),
  .latch_o  (latch_o)
);
`default_nettype wire
